FILE: src/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkv_ctrl, lkv_datapath and the lru_key_value_cache top level.
`default_nettype none

package lkv_pkg;

  // Capacity register width and its value after reset
  localparam int CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Controller sequence for one item
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY,
    ST_EMIT
  } lkv_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic do_match;
    logic do_apply;
    logic load_out;
  } lkv_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
  } lkv_stat_t;

endpackage

`default_nettype wire

FILE: src/lkv_ctrl.sv
// Controller state machine for the LRU key-value cache.
// Depends on lkv_pkg for the state enum and the command/status structs.
`default_nettype none

module lkv_ctrl
  import lkv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire lkv_stat_t stat,
  output lkv_cmd_t       cmd
);

  lkv_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_EMIT;
      ST_EMIT:  if (stat.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_MATCH: cmd.do_match = 1'b1;
      ST_APPLY: cmd.do_apply = 1'b1;
      ST_EMIT:  cmd.load_out = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/lkv_datapath.sv
// Datapath of the LRU key-value cache: key CAM, valid bits, recency ranks,
// value memory, capacity register and result register. Depends on lkv_pkg.
`default_nettype none

module lkv_datapath
  import lkv_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lkv_cmd_t              cmd,
  output lkv_stat_t                  stat,
  input  wire logic                  cfg_we,
  input  wire logic [CAP_BITS-1:0]   cfg_wdata,
  input  wire logic                  in_action,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_hit,
  output logic [VALUE_BITS-1:0]      out_read_value,
  output logic                       out_evicted
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  // Item latch
  logic                  act_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // Entry state
  logic [KEY_BITS-1:0]   cam_key_r [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;
  logic [RANK_W-1:0]     rank_r    [ENTRIES];
  logic [CNT_W-1:0]      used_r;
  logic [CAP_BITS-1:0]   cap_r;
  logic [VALUE_BITS-1:0] val_mem   [ENTRIES];
  logic [VALUE_BITS-1:0] rd_data_r;

  // Match results
  logic              hit_r;
  logic              evict_r;
  logic              fill_r;
  logic              age_all_r;
  logic [IDX_W-1:0]  slot_r;
  logic [RANK_W-1:0] lim_r;

  // Result register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic                  out_evicted_r;
  logic [VALUE_BITS-1:0] out_read_value_r;

  // Match stage combinational signals
  logic              hit_c;
  logic [IDX_W-1:0]  hit_idx_c;
  logic [IDX_W-1:0]  free_idx_c;
  logic [IDX_W-1:0]  lru_idx_c;
  logic [RANK_W-1:0] oldest_rank_c;
  logic              fill_ok_c;
  logic [CMP_W-1:0]  used_cmp_c;
  logic [CMP_W-1:0]  cap_cmp_c;

  // Item latch on accept
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r <= in_action;
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Parallel key compare, free-slot and oldest-entry search (lowest index wins)
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    lru_idx_c  = '0;
    oldest_rank_c = RANK_W'(used_r - CNT_W'(1));
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (cam_key_r[i] == key_r)) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx_c = IDX_W'(i);
      end
      if (valid_r[i] && (rank_r[i] == oldest_rank_c)) begin
        lru_idx_c = IDX_W'(i);
      end
    end
  end

  // Room to fill: capacity zero counts as one, above ENTRIES as ENTRIES
  always_comb begin
    used_cmp_c = CMP_W'(used_r);
    cap_cmp_c  = CMP_W'(cap_r);
    fill_ok_c  = (used_r < FULL_CNT) &&
                 ((used_cmp_c < cap_cmp_c) || ((cap_r == '0) && (used_r == '0)));
  end

  // Match stage: choose the slot and how ranks age
  always_ff @(posedge clk) begin
    if (cmd.do_match) begin
      hit_r     <= hit_c;
      evict_r   <= 1'b0;
      fill_r    <= 1'b0;
      age_all_r <= 1'b0;
      lim_r     <= rank_r[hit_idx_c];
      slot_r    <= hit_idx_c;
      if (!hit_c && act_r) begin
        if (fill_ok_c) begin
          slot_r    <= free_idx_c;
          fill_r    <= 1'b1;
          age_all_r <= 1'b1;
        end else begin
          slot_r  <= lru_idx_c;
          lim_r   <= oldest_rank_c;
          evict_r <= 1'b1;
        end
      end
    end
  end

  // Apply stage: ranks, valid bits and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.do_apply && (hit_r || act_r)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == slot_r) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && (age_all_r || (rank_r[i] < lim_r))) begin
          rank_r[i] <= rank_r[i] + RANK_W'(1);
        end
      end
      if (fill_r) begin
        valid_r[slot_r] <= 1'b1;
        used_r          <= used_r + CNT_W'(1);
      end
    end
  end

  // Apply stage: key store for a new key
  always_ff @(posedge clk) begin
    if (cmd.do_apply && act_r && !hit_r) begin
      cam_key_r[slot_r] <= key_r;
    end
  end

  // Value memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.do_apply) begin
      rd_data_r <= val_mem[slot_r];
      if (act_r) begin
        val_mem[slot_r] <= val_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r        <= hit_r;
      out_evicted_r    <= evict_r;
      out_read_value_r <= (hit_r && !act_r) ? rd_data_r : '0;
    end
  end

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_evicted    = out_evicted_r;
  assign out_read_value = out_read_value_r;

endmodule

`default_nettype wire

FILE: src/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkv_pkg, lkv_ctrl and lkv_datapath.
//
//   port group  direction  handshake            payload
//   in_         input      in_valid / in_stall   in_action, in_key, in_value
//   out_        output     out_valid / out_stall out_hit, out_read_value, out_evicted
//   cfg_        input      cfg_we                cfg_wdata (capacity)
//
// Each item runs accept, key match, entry update with value memory read
// and result load once the output is free. The single-port value memory
// is read after the slot is chosen. A new item is accepted while the
// previous result still sits in the output register. Reset is synchronous,
// active low; it clears valid bits, ranks, fill count and sets capacity 16.
`default_nettype none

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CAP_BITS-1:0]   cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_action,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_hit,
  output logic [VALUE_BITS-1:0]      out_read_value,
  output logic                       out_evicted
);

  lkv_cmd_t  cmd;
  lkv_stat_t stat;

  // Sequencer
  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Entry storage and result register
  lkv_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted)
  );

endmodule

`default_nettype wire

FILE: sim/lkv_tb_pkg.sv
// Testbench-side codes for the LRU key-value cache bench.
// Used by lkv_checker and tb_lru_key_value_cache; no other dependencies.
package lkv_tb_pkg;

  // Meaning of the in_action bit
  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_WRITE  = 1'b1
  } lkv_action_t;

  // Output stall patterns of the receiving side
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_BEAT
  } rx_mode_t;

endpackage

FILE: sim/lkv_checker.sv
// Checker for the LRU key-value cache: watches the config, input and result
// channels, keeps its own copy of the cache and compares every result item.
// Depends on lkv_pkg (capacity width, reset value) and lkv_tb_pkg.
module lkv_checker
  import lkv_pkg::*;
  import lkv_tb_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CAP_BITS-1:0]   cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_action,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_hit,
  input  logic [VALUE_BITS-1:0] out_read_value,
  input  logic                  out_evicted,
  output int                    mismatch_cnt,
  output int                    outstanding
);

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
  } cache_reply_t;

  // Shadow cache contents
  logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
  logic [VALUE_BITS-1:0] slot_val   [ENTRIES];
  logic                  slot_valid [ENTRIES];
  int                    slot_rank  [ENTRIES];
  int                    fill_cnt;
  logic [CAP_BITS-1:0]   cap_reg;

  cache_reply_t reply_q[$];

  initial mismatch_cnt = 0;
  initial outstanding  = 0;

  function automatic int cap_in_use();
    if (cap_reg == '0) return 1;
    if (int'(cap_reg) > ENTRIES) return ENTRIES;
    return int'(cap_reg);
  endfunction

  // Make one slot most recent; valid slots ranked below the limit age by one
  task automatic promote(input int slot, input int limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != slot && slot_valid[i] && slot_rank[i] < limit) slot_rank[i]++;
    end
    slot_rank[slot] = 0;
  endtask

  // Apply one lookup or write to the shadow cache and form its reply
  task automatic lru_access(input logic act, input logic [KEY_BITS-1:0] k,
                            input logic [VALUE_BITS-1:0] v, output cache_reply_t r);
    int hit_idx;
    int slot;
    int worst;
    hit_idx = -1;
    slot    = -1;
    worst   = 0;
    r       = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_idx < 0 && slot_valid[i] && slot_key[i] == k) hit_idx = i;
    end
    if (hit_idx >= 0) begin
      r.hit = 1'b1;
      if (act == ACT_LOOKUP) r.read_value = slot_val[hit_idx];
      else slot_val[hit_idx] = v;
      promote(hit_idx, slot_rank[hit_idx]);
    end else if (act == ACT_WRITE) begin
      if (fill_cnt < cap_in_use() && fill_cnt < ENTRIES) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !slot_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        // free slot: everyone else ages
        slot_valid[slot] = 1'b1;
        fill_cnt++;
        promote(slot, 32'h7fff_ffff);
      end else begin
        // replace the least recent valid slot
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && (slot < 0 || slot_rank[i] > worst)) begin
            slot  = i;
            worst = slot_rank[i];
          end
        end
        if (slot < 0) begin
          slot          = 0;
          slot_valid[0] = 1'b1;
          fill_cnt      = 1;
          worst         = 0;
        end else begin
          r.evicted = 1'b1;
        end
        promote(slot, worst);
      end
      slot_key[slot] = k;
      slot_val[slot] = v;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [VALUE_BITS-1:0] got,
                                 input logic [VALUE_BITS-1:0] want);
    if (mismatch_cnt < 200)
      $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Track traffic on every edge
  always @(posedge clk) begin
    cache_reply_t pred;
    cache_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = 0;
      end
      fill_cnt = 0;
      cap_reg  = CAP_RESET;
      reply_q.delete();
    end else begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (in_valid && !in_stall) begin
        lru_access(in_action, in_key, in_value, pred);
        reply_q.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected result item", out_read_value, '0);
        end else begin
          want = reply_q.pop_front();
          if (out_hit !== want.hit)
            report_mismatch("hit", VALUE_BITS'(out_hit), VALUE_BITS'(want.hit));
          if (out_read_value !== want.read_value)
            report_mismatch("read_value", out_read_value, want.read_value);
          if (out_evicted !== want.evicted)
            report_mismatch("evicted", VALUE_BITS'(out_evicted), VALUE_BITS'(want.evicted));
        end
      end
    end
    outstanding <= reply_q.size();
  end

endmodule

FILE: sim/tb_lru_key_value_cache.sv
// Testbench top for lru_key_value_cache: reset, clock, stimulus and verdict.
// Depends on lkv_pkg, lkv_tb_pkg, lkv_checker and the cache RTL.
module tb_lru_key_value_cache
  import lkv_pkg::*;
  import lkv_tb_pkg::*;
();

  localparam int ENTRIES     = 16;
  localparam int KEY_BITS    = 16;
  localparam int VALUE_BITS  = 32;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 150;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CAP_BITS-1:0]   cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_action = 1'b0;
  logic [KEY_BITS-1:0]   in_key    = '0;
  logic [VALUE_BITS-1:0] in_value  = '0;
  logic                  out_stall = 1'b0;
  logic                  hold_go   = 1'b0;
  wire                   in_stall;
  wire                   out_valid;
  wire                   out_hit;
  wire [VALUE_BITS-1:0]  out_read_value;
  wire                   out_evicted;
  int                    mismatches;
  int                    outstanding;
  int                    burst_left = 0;
  logic [KEY_BITS-1:0]   key_pool[$];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  lru_key_value_cache #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .out_evicted   (out_evicted)
  );

  lkv_checker #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .out_evicted   (out_evicted),
    .mismatch_cnt  (mismatches),
    .outstanding   (outstanding)
  );

  // Offer one item in bursts; returns at the edge where it is accepted
  task automatic offer(input lkv_action_t act, input logic [KEY_BITS-1:0] k,
                       input logic [VALUE_BITS-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_action <= act;
    in_key    <= k;
    in_value  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every result item has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_capacity(input logic [CAP_BITS-1:0] c);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One capacity setting with random traffic over a key pool a bit larger
  // than the capacity, so hits, updates and evictions all occur
  task automatic run_phase(input logic [CAP_BITS-1:0] c, input int n_items,
                           input bit with_hold, input bit with_pause);
    int eff;
    int pool_n;
    logic [KEY_BITS-1:0] k;
    logic [VALUE_BITS-1:0] v;
    lkv_action_t act;
    set_capacity(c);
    eff    = (c == '0) ? 1 : (int'(c) > ENTRIES) ? ENTRIES : int'(c);
    pool_n = eff + $urandom_range(1, 6);
    key_pool.delete();
    for (int i = 0; i < pool_n; i++) key_pool.push_back(KEY_BITS'($urandom));
    key_pool[0] = $urandom_range(0, 1) ? '0 : '1;
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == 20) hold_go <= 1'b1;
      if (with_pause && i == n_items / 2) settle();
      // mostly pool keys, some stray keys as noise
      k   = ($urandom_range(0, 99) < 8) ? KEY_BITS'($urandom)
                                        : key_pool[$urandom_range(0, pool_n - 1)];
      act = lkv_action_t'($urandom_range(0, 1));
      case ($urandom_range(0, 15))
        0:       v = '0;
        1:       v = '1;
        default: v = VALUE_BITS'($urandom);
      endcase
      offer(act, k, v);
    end
  endtask

  // Receiver stall patterns, plus one long hold-off on request
  initial begin : receiver
    int seg_left;
    int hold_left;
    int tick;
    bit held;
    rx_mode_t mode;
    seg_left  = 0;
    hold_left = 0;
    tick      = 0;
    held      = 1'b0;
    mode      = RX_FREE;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= tick[1];
        endcase
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("tb_lru_key_value_cache failed");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty cache, key and value extremes, update, fill, eviction
    offer(ACT_LOOKUP, '0, '1);
    offer(ACT_WRITE, '0, '0);
    offer(ACT_WRITE, '1, '1);
    offer(ACT_LOOKUP, '0, '0);
    offer(ACT_LOOKUP, '1, '0);
    offer(ACT_WRITE, '1, '0);
    offer(ACT_LOOKUP, '1, '1);
    offer(ACT_LOOKUP, 16'h1234, 32'haaaa_aaaa);
    for (int i = 1; i <= 14; i++)
      offer(ACT_WRITE, KEY_BITS'(i), (i % 2) ? 32'haaaa_5555 : 32'h5555_aaaa);
    offer(ACT_WRITE, 16'h8000, 32'h8000_0001);
    offer(ACT_LOOKUP, '0, '0);
    offer(ACT_LOOKUP, 16'h8000, '0);

    // Capacity settings: shrink below the fill count, zero, above range, extremes
    run_phase(5'd1, 180, 1'b0, 1'b0);
    run_phase(5'd0, 150, 1'b0, 1'b0);
    run_phase(5'd31, 200, 1'b1, 1'b0);
    run_phase(5'd17, 180, 1'b0, 1'b0);
    run_phase(CAP_RESET, 200, 1'b0, 1'b1);
    run_phase(5'd3, 180, 1'b0, 1'b0);
    for (int i = 0; i < 3; i++) run_phase(CAP_BITS'($urandom_range(0, 31)), 150, 1'b0, 1'b0);

    settle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) $display("tb_lru_key_value_cache passed");
    else $display("tb_lru_key_value_cache failed");
    $finish;
  end

endmodule
